// ----- rtl/substitution_profile_sampler_macros.svh -----
// assertion macros for the substitution profile sampler checker
// expects clk and arst_n in the scope of use
`ifndef SUBSTITUTION_PROFILE_SAMPLER_MACROS_SVH
`define SUBSTITUTION_PROFILE_SAMPLER_MACROS_SVH

// same-cycle implication
`define SPS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sps assertion failed");

// next-cycle implication
`define SPS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sps assertion failed");

`endif

// ----- rtl/sps_pkg.sv -----
// shared types, constants and helpers of the substitution profile sampler
// used by every module of the block
package sps_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int FRACTION_BITS = 16;
	localparam int COUNT_BITS    = 32;
	localparam int CELLS         = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int ADDR_W        = $clog2(CELLS);
	localparam int IDX_W         = $clog2(ALPHABET_SIZE);
	localparam int LEN_W         = $clog2(ALPHABET_SIZE + 1);
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int SUM_W         = FRAC_W + IDX_W;
	localparam int DIVD_W        = COUNT_BITS + FRACTION_BITS;
	localparam int MASK_W        = 26;
	localparam int LETTER_BASE   = 65;

	localparam logic [1:0] CMD_OBSERVE  = 2'd0;
	localparam logic [1:0] CMD_FINALIZE = 2'd1;
	localparam logic [1:0] CMD_MUTATE   = 2'd2;
	localparam logic [1:0] CMD_CLEAR    = 2'd3;

	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRACTION_BITS;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  first_char;
		logic [7:0]  second_char;
		logic [31:0] amount;
		logic [16:0] rate_frac;
		logic [15:0] draw_rate;
		logic [15:0] draw_pick;
	} req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       changed;
		logic       counted;
		logic       bad_char;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]     addr;
		logic                  cnt_we;
		logic [COUNT_BITS-1:0] cnt_wd;
		logic                  frac_we;
		logic [FRAC_W-1:0]     frac_wd;
		logic                  rank_we;
		logic [IDX_W-1:0]      rank_wd;
	} store_req_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] cnt;
		logic [FRAC_W-1:0]     frac;
		logic [IDX_W-1:0]      rank;
	} store_rsp_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		cell_addr = ADDR_W'(row) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(col);
	endfunction

	function automatic logic in_range(input logic [7:0] c);
		in_range = (c >= 8'(LETTER_BASE)) && (c < 8'(LETTER_BASE + ALPHABET_SIZE));
	endfunction

	function automatic logic [IDX_W-1:0] letter_idx(input logic [7:0] c);
		letter_idx = IDX_W'(c - 8'(LETTER_BASE));
	endfunction

	function automatic logic in_alpha(input logic [MASK_W-1:0] mask,
		input logic [IDX_W-1:0] idx);
		logic [31:0] wide;
		wide = 32'(mask);
		in_alpha = (32'(idx) < 32'(MASK_W)) && wide[idx];
	endfunction

endpackage

// ----- rtl/sps_store.sv -----
// count, fraction and rank tables with one shared address and registered reads
// depends on sps_pkg
module sps_store (
	input  logic                clk,
	input  sps_pkg::store_req_t req,
	output sps_pkg::store_rsp_t rsp
);
	import sps_pkg::*;

	logic [COUNT_BITS-1:0] cnt_mem  [CELLS];
	logic [FRAC_W-1:0]     frac_mem [CELLS];
	logic [IDX_W-1:0]      rank_mem [CELLS];

	always_ff @(posedge clk) begin
		if (req.cnt_we) begin
			cnt_mem[req.addr] <= req.cnt_wd;
		end
		if (req.frac_we) begin
			frac_mem[req.addr] <= req.frac_wd;
		end
		if (req.rank_we) begin
			rank_mem[req.addr] <= req.rank_wd;
		end
		rsp.cnt  <= cnt_mem[req.addr];
		rsp.frac <= frac_mem[req.addr];
		rsp.rank <= rank_mem[req.addr];
	end

endmodule

// ----- rtl/sps_div.sv -----
// restoring divider, one quotient bit per cycle, result saturated at one
// depends on sps_pkg
module sps_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sps_pkg::COUNT_BITS-1:0] count,
	input  logic [sps_pkg::COUNT_BITS-1:0] divisor,
	output logic                          done,
	output logic [sps_pkg::FRAC_W-1:0]     quot
);
	import sps_pkg::*;

	localparam int ITER_W = $clog2(DIVD_W + 1);

	logic [COUNT_BITS:0]   rem_q;
	logic [DIVD_W-1:0]     dvd_q;
	logic [COUNT_BITS-1:0] dvs_q;
	logic [FRAC_W-1:0]     q_q;
	logic                  ovf_q;
	logic [ITER_W-1:0]     iter_q;
	logic                  busy_q;
	logic [COUNT_BITS:0]   rem_sh;
	logic                  qbit;

	assign rem_sh = {rem_q[COUNT_BITS-1:0], dvd_q[DIVD_W-1]};
	assign qbit   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			iter_q <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
			q_q    <= '0;
			ovf_q  <= 1'b0;
			quot   <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
				rem_q  <= '0;
				dvd_q  <= {count, FRACTION_BITS'(0)};
				dvs_q  <= divisor;
				q_q    <= '0;
				ovf_q  <= 1'b0;
			end else if (busy_q) begin
				rem_q  <= qbit ? rem_sh - {1'b0, dvs_q} : rem_sh;
				dvd_q  <= dvd_q << 1;
				q_q    <= {q_q[FRAC_W-2:0], qbit};
				ovf_q  <= ovf_q | q_q[FRAC_W-1];
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					if (ovf_q || q_q[FRAC_W-1] || ({q_q[FRAC_W-2:0], qbit} > FRAC_ONE)) begin
						quot <= FRAC_ONE;
					end else begin
						quot <= {q_q[FRAC_W-2:0], qbit};
					end
				end
			end
		end
	end

endmodule

// ----- rtl/substitution_profile_sampler.sv -----
// top level: register port, command sequencer and result register
// depends on sps_pkg, sps_store and sps_div
//
// One transaction at a time. Observe reads and writes back the pair's count cell when the pair
// is counted; mutate walks the ranked letters of the row (up to 26); clear runs a sweep over
// all 676 cells of the tables. Finalize sums each row, passes each cell of a nonzero row through
// the single divider (read, divide, write), then ranks each alphabet row letter by letter (load,
// scan, write). A stalled response keeps the sequencer waiting in its done state. After reset
// the same sweep runs before the first transaction is taken; register writes are taken throughout.
module substitution_profile_sampler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          req_valid,
	output logic          req_stall,
	input  sps_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sps_pkg::rsp_t rsp
);
	import sps_pkg::*;

	typedef enum logic [14:0] {
		S_SWEEP    = 15'b000000000000001,
		S_IDLE     = 15'b000000000000010,
		S_OBS_RD   = 15'b000000000000100,
		S_OBS_WR   = 15'b000000000001000,
		S_SUM      = 15'b000000000010000,
		S_DIV_RD   = 15'b000000000100000,
		S_DIV_RUN  = 15'b000000001000000,
		S_RK_ROW   = 15'b000000010000000,
		S_RK_LOAD  = 15'b000000100000000,
		S_RK_SCAN  = 15'b000001000000000,
		S_RK_WR    = 15'b000010000000000,
		S_MUT_RANK = 15'b000100000000000,
		S_MUT_FRAC = 15'b001000000000000,
		S_DONE     = 15'b010000000000000,
		S_SPARE    = 15'b100000000000000
	} state_t;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(ALPHABET_SIZE - 1);
	localparam int CMP_W = SUM_W + 16;

	state_t                state_q;
	logic [7:0]            ign_q;
	logic [MASK_W-1:0]     mask_q;
	req_t                  req_q;
	rsp_t                  res_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic                  clr_q;
	logic                  phase_q;
	logic [IDX_W-1:0]      row_q;
	logic [IDX_W-1:0]      col_q;
	logic [IDX_W-1:0]      k_q;
	logic [IDX_W-1:0]      pos_q;
	logic [LEN_W-1:0]      n_q;
	logic [LEN_W-1:0]      mlen_q;
	logic [COUNT_BITS-1:0] sum_q;
	logic [FRAC_W-1:0]     fc_q;
	logic [SUM_W-1:0]      msum_q;
	logic [LEN_W-1:0]      rank_len_q [ALPHABET_SIZE];

	store_req_t            st_req;
	store_rsp_t            st_rsp;
	logic                  div_start;
	logic                  div_done;
	logic [FRAC_W-1:0]     div_quot;
	logic [IDX_W-1:0]      col_sel;
	logic                  cfg_wr;
	logic                  req_acc;
	logic                  out_free;
	logic [COUNT_BITS-1:0] sum_next;
	logic [SUM_W-1:0]      msum_next;
	logic                  pick_hit;
	logic                  less_key;
	rsp_t                  res_init;
	rsp_t                  res_bad;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = paddr[2] ? 32'(mask_q) : 32'(ign_q);

	assign req_stall = state_q != S_IDLE;
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign res_init = '{out_char: req.first_char, changed: 1'b0, counted: 1'b0, bad_char: 1'b0};
	assign res_bad  = '{out_char: req.first_char, changed: 1'b0, counted: 1'b0, bad_char: 1'b1};

	assign sum_next  = sum_q + st_rsp.cnt;
	assign msum_next = msum_q + SUM_W'(st_rsp.frac);
	assign pick_hit  = (CMP_W'(msum_next) << 16) > (CMP_W'(req_q.draw_pick) << FRACTION_BITS);
	assign less_key  = in_alpha(mask_q, k_q)
		&& ((st_rsp.frac < fc_q) || ((st_rsp.frac == fc_q) && (k_q < col_q)));

	always_comb begin
		case (state_q)
			S_RK_SCAN, S_MUT_RANK: col_sel = k_q;
			S_RK_WR:               col_sel = pos_q;
			default:               col_sel = col_q;
		endcase
	end

	always_comb begin
		st_req         = '0;
		st_req.addr    = cell_addr(row_q, col_sel);
		st_req.rank_wd = col_q;
		st_req.frac_wd = div_quot;
		st_req.cnt_wd  = st_rsp.cnt + req_q.amount;
		case (state_q)
			S_SWEEP: begin
				st_req.cnt_we  = 1'b1;
				st_req.frac_we = 1'b1;
				st_req.rank_we = 1'b1;
				st_req.cnt_wd  = '0;
				st_req.frac_wd = '0;
			end
			S_OBS_WR:  st_req.cnt_we  = 1'b1;
			S_DIV_RUN: st_req.frac_we = div_done;
			S_RK_WR:   st_req.rank_we = 1'b1;
			default: begin
			end
		endcase
	end

	assign div_start = (state_q == S_DIV_RD) && phase_q;

	sps_store u_store (
		.clk (clk),
		.req (st_req),
		.rsp (st_rsp)
	);

	sps_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.count   (st_rsp.cnt),
		.divisor (sum_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_q  <= 8'd45;
			mask_q <= '1;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				mask_q <= pwdata[MASK_W-1:0];
			end else begin
				ign_q <= pwdata[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			req_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			clr_q       <= 1'b0;
			phase_q     <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			k_q         <= '0;
			pos_q       <= '0;
			n_q         <= '0;
			mlen_q      <= '0;
			sum_q       <= '0;
			fc_q        <= '0;
			msum_q      <= '0;
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				rank_len_q[i] <= LEN_W'(ALPHABET_SIZE);
			end
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_SWEEP: begin
					if (col_q == LAST) begin
						col_q <= '0;
						if (row_q == LAST) begin
							row_q   <= '0;
							state_q <= clr_q ? S_DONE : S_IDLE;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						req_q   <= req;
						phase_q <= 1'b0;
						sum_q   <= '0;
						case (req.cmd)
							CMD_OBSERVE: begin
								if (req.first_char != req.second_char
									&& req.first_char != ign_q && req.second_char != ign_q) begin
									if (in_range(req.first_char) && in_range(req.second_char)) begin
										res_q   <= res_init;
										row_q   <= letter_idx(req.first_char);
										col_q   <= letter_idx(req.second_char);
										state_q <= S_OBS_RD;
									end else begin
										res_q   <= res_bad;
										state_q <= S_DONE;
									end
								end else begin
									res_q   <= res_init;
									state_q <= S_DONE;
								end
							end
							CMD_FINALIZE: begin
								res_q   <= res_init;
								state_q <= S_SUM;
							end
							CMD_MUTATE: begin
								if (!in_range(req.first_char)
									|| !in_alpha(mask_q, letter_idx(req.first_char))) begin
									res_q   <= res_bad;
									state_q <= S_DONE;
								end else if (17'(req.draw_rate) <= req.rate_frac
									&& rank_len_q[letter_idx(req.first_char)] != '0) begin
									res_q   <= res_init;
									row_q   <= letter_idx(req.first_char);
									k_q     <= '0;
									msum_q  <= '0;
									mlen_q  <= rank_len_q[letter_idx(req.first_char)];
									state_q <= S_MUT_RANK;
								end else begin
									res_q   <= res_init;
									state_q <= S_DONE;
								end
							end
							default: begin
								res_q   <= res_init;
								clr_q   <= 1'b1;
								state_q <= S_SWEEP;
								for (int i = 0; i < ALPHABET_SIZE; i++) begin
									rank_len_q[i] <= LEN_W'(ALPHABET_SIZE);
								end
							end
						endcase
					end
				end
				S_OBS_RD: state_q <= S_OBS_WR;
				S_OBS_WR: begin
					res_q.counted <= 1'b1;
					state_q       <= S_DONE;
				end
				S_SUM: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (col_q == LAST) begin
							col_q <= '0;
							if (sum_next != '0) begin
								sum_q   <= sum_next;
								state_q <= S_DIV_RD;
							end else begin
								sum_q <= '0;
								if (row_q == LAST) begin
									row_q   <= '0;
									state_q <= S_RK_ROW;
								end else begin
									row_q <= row_q + 1'b1;
								end
							end
						end else begin
							sum_q <= sum_next;
							col_q <= col_q + 1'b1;
						end
					end
				end
				S_DIV_RD: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						state_q <= S_DIV_RUN;
					end
				end
				S_DIV_RUN: begin
					if (div_done) begin
						phase_q <= 1'b0;
						if (col_q == LAST) begin
							col_q <= '0;
							sum_q <= '0;
							if (row_q == LAST) begin
								row_q   <= '0;
								state_q <= S_RK_ROW;
							end else begin
								row_q   <= row_q + 1'b1;
								state_q <= S_SUM;
							end
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= S_DIV_RD;
						end
					end
				end
				S_RK_ROW: begin
					phase_q <= 1'b0;
					col_q   <= '0;
					n_q     <= '0;
					if (in_alpha(mask_q, row_q)) begin
						state_q <= S_RK_LOAD;
					end else if (row_q == LAST) begin
						state_q <= S_DONE;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				S_RK_LOAD: begin
					if (!in_alpha(mask_q, col_q)) begin
						if (col_q == LAST) begin
							rank_len_q[row_q] <= n_q;
							if (row_q == LAST) begin
								state_q <= S_DONE;
							end else begin
								row_q   <= row_q + 1'b1;
								state_q <= S_RK_ROW;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end else begin
						phase_q <= !phase_q;
						if (phase_q) begin
							fc_q    <= st_rsp.frac;
							k_q     <= '0;
							pos_q   <= '0;
							state_q <= S_RK_SCAN;
						end
					end
				end
				S_RK_SCAN: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (less_key) begin
							pos_q <= pos_q + 1'b1;
						end
						if (k_q == LAST) begin
							state_q <= S_RK_WR;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_RK_WR: begin
					phase_q <= 1'b0;
					n_q     <= n_q + 1'b1;
					if (col_q == LAST) begin
						rank_len_q[row_q] <= n_q + 1'b1;
						if (row_q == LAST) begin
							state_q <= S_DONE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_RK_ROW;
						end
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= S_RK_LOAD;
					end
				end
				S_MUT_RANK: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						col_q   <= st_rsp.rank;
						state_q <= S_MUT_FRAC;
					end
				end
				S_MUT_FRAC: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						msum_q <= msum_next;
						if (pick_hit) begin
							res_q.out_char <= 8'(LETTER_BASE) + 8'(col_q);
							res_q.changed  <= 1'b1;
							state_q        <= S_DONE;
						end else if (LEN_W'(k_q) + 1'b1 >= mlen_q) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_MUT_RANK;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						clr_q       <= 1'b0;
						row_q       <= '0;
						col_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/sps_checker.sv -----
// port-level checker for the substitution profile sampler, bound to the top level
// depends on sps_pkg and substitution_profile_sampler_macros.svh
`include "substitution_profile_sampler_macros.svh"

module sps_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          psel,
	input logic          penable,
	input logic          pwrite,
	input logic [2:0]    paddr,
	input logic [31:0]   pwdata,
	input logic [31:0]   prdata,
	input logic          pready,
	input logic          req_valid,
	input logic          req_stall,
	input sps_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input sps_pkg::rsp_t rsp
);
	import sps_pkg::*;

	`SPS_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`SPS_ASSERT_IMP(a_flags_excl, rsp_valid, !(rsp.changed && (rsp.counted || rsp.bad_char)))
	`SPS_ASSERT_IMP(a_count_good, rsp_valid && rsp.counted, !rsp.bad_char)
	`SPS_ASSERT_NXT(a_busy_after, req_valid && !req_stall, req_stall)
	`SPS_ASSERT_IMP(a_ready, psel, pready)

endmodule

bind substitution_profile_sampler sps_checker u_sps_checker (.*);
